/* src/sstc_pkg.sv */
// ----------------------------------------------------------------------------
// sstc_pkg - shared constants for the stack signature count table
// Default sizes and the bit layout of the result word.
// ----------------------------------------------------------------------------
package sstc_pkg;

    localparam int TABLE_ENTRIES_DEF  = 256;
    localparam int FRAMES_PER_KEY_DEF = 64;

    localparam int ADDR_W    = 64;
    localparam int COUNT_W   = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;

    // result word layout, lowest bit first
    localparam int RES_IDX_LSB   = 0;
    localparam int RES_CNT_LSB   = 8;
    localparam int RES_INS_BIT   = 40;
    localparam int RES_DROP_BIT  = 41;
    localparam int RES_DIST_LSB  = 42;
    localparam int RES_TOTAL_LSB = 51;
    localparam int RES_USED_W    = 83;

endpackage

/* src/sstc_ram.sv */
// ----------------------------------------------------------------------------
// sstc_ram - single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sstc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/stack_signature_count_table.sv */
// ----------------------------------------------------------------------------
// stack_signature_count_table - distinct call-stack sample counter
// Buffers the frames of a sample, then walks the table for an equal key,
// raising its count or inserting a new entry.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tlast      | tuser
// s_      | in  | frame_address                  | last_frame | empty_sample
// m_      | out | index,count,ins,drop,dist,total| -          | -
//
// A frame that is not last is buffered in the pending memory while there is
// room. A last frame starts the search: each entry has its length read and
// checked, and on an equal length its frames are compared one at a time,
// through one compare unit fed by the key and pending memories. A miss copies
// the key frame by frame into a new entry, or drops the sample when the table
// is full; a hit reads the entry's count and raises it.
// Reset (synchronous, active low) clears the fill count, total, frame count,
// result valid, indices and FSM, not the memories. A stalled result holds;
// non-last frames are still taken meanwhile.
module stack_signature_count_table
    import sstc_pkg::*;
#(
    parameter int TABLE_ENTRIES  = TABLE_ENTRIES_DEF,
    parameter int FRAMES_PER_KEY = FRAMES_PER_KEY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // frame_address[63:0]
    input  logic                 s_tlast,
    input  logic                 s_tuser,  // empty_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry_index[7:0], entry_count[39:8], was_inserted[40], was_dropped[41],
    // distinct_stacks[50:42], total_samples[82:51], zero[87:83]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int EW  = $clog2(TABLE_ENTRIES + 1);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int LW  = $clog2(FRAMES_PER_KEY + 1);
    localparam int FW  = $clog2(FRAMES_PER_KEY);
    localparam int KAW = $clog2(TABLE_ENTRIES * FRAMES_PER_KEY);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN_RD, ST_LEN_CHK, ST_FR_RD, ST_FR_CHK, ST_CNT_RD,
        ST_CNT_UPD, ST_MISS, ST_CP_RD, ST_CP_WR, ST_DONE
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    state_t               state_reg;
    logic [EW-1:0]        e_reg;
    logic [EW-1:0]        used_reg;
    logic [FW-1:0]        i_reg;
    logic [LW-1:0]        plen_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [COUNT_W-1:0]   rcnt_reg;
    logic                 rins_reg;
    logic                 rdrop_reg;
    logic                 mvalid_reg;
    logic [M_TDATA_W-1:0] mdata_reg;

    logic [ADDR_W-1:0]  pend_q;
    logic [ADDR_W-1:0]  key_q;
    logic [LW-1:0]      len_q;
    logic [COUNT_W-1:0] cnt_q;
    logic [KAW-1:0]     key_addr;
    logic [IW-1:0]      e_idx;
    logic               s_acc;
    logic               pend_we;
    logic               last_i;
    logic               cnt_we;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               cp_last_we;
    logic [COUNT_W-1:0] total_next;
    logic [31:0]        e_wide;
    logic [31:0]        used_wide;
    logic               out_free;

    assign e_idx    = e_reg[IW-1:0];
    assign key_addr = KAW'(32'(e_idx) * FRAMES_PER_KEY + 32'(i_reg));
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign pend_we  = s_acc && !s_tuser && (plen_reg < LW'(FRAMES_PER_KEY));
    assign last_i   = (LW'(i_reg) == plen_reg - LW'(1));
    assign cp_last_we = (state_reg == ST_CP_WR) && last_i;
    assign cnt_we   = (state_reg == ST_CNT_UPD) || cp_last_we;
    assign cnt_wdata = (state_reg == ST_CNT_UPD) ? sat_inc(cnt_q) : COUNT_W'(1);
    assign total_next = sat_inc(total_reg);
    assign e_wide    = 32'(e_reg);
    assign used_wide = 32'(used_reg);
    assign out_free  = !mvalid_reg || m_tready;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    sstc_ram #(.DEPTH(FRAMES_PER_KEY), .WIDTH(ADDR_W)) u_pend (
        .aclk(aclk), .wr_en(pend_we), .wr_addr(plen_reg[FW-1:0]),
        .wr_data(s_tdata), .rd_addr(i_reg), .rd_data(pend_q)
    );

    sstc_ram #(.DEPTH(TABLE_ENTRIES * FRAMES_PER_KEY), .WIDTH(ADDR_W)) u_keys (
        .aclk(aclk), .wr_en(state_reg == ST_CP_WR), .wr_addr(key_addr),
        .wr_data(pend_q), .rd_addr(key_addr), .rd_data(key_q)
    );

    sstc_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(LW)) u_lens (
        .aclk(aclk), .wr_en(cp_last_we), .wr_addr(e_idx),
        .wr_data(plen_reg), .rd_addr(e_idx), .rd_data(len_q)
    );

    sstc_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(COUNT_W)) u_cnts (
        .aclk(aclk), .wr_en(cnt_we), .wr_addr(e_idx),
        .wr_data(cnt_wdata), .rd_addr(e_idx), .rd_data(cnt_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            plen_reg   <= '0;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
            e_reg      <= '0;
            i_reg      <= '0;
        end else begin
            // drop the taken result unless a new one replaces it this cycle
            if (mvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser) begin
                            plen_reg  <= '0;
                            total_reg <= total_next;
                        end else begin
                            if (pend_we) begin
                                plen_reg <= plen_reg + LW'(1);
                            end
                            if (s_tlast) begin
                                e_reg     <= '0;
                                state_reg <= ST_LEN_RD;
                            end
                        end
                    end
                end
                ST_LEN_RD: begin
                    state_reg <= (e_reg == used_reg) ? ST_MISS : ST_LEN_CHK;
                end
                ST_LEN_CHK: begin
                    i_reg <= '0;
                    if (len_q == plen_reg) begin
                        state_reg <= ST_FR_RD;
                    end else begin
                        e_reg     <= e_reg + EW'(1);
                        state_reg <= ST_LEN_RD;
                    end
                end
                ST_FR_RD: begin
                    state_reg <= ST_FR_CHK;
                end
                ST_FR_CHK: begin
                    priority if (key_q != pend_q) begin
                        e_reg     <= e_reg + EW'(1);
                        state_reg <= ST_LEN_RD;
                    end else if (last_i) begin
                        state_reg <= ST_CNT_RD;
                    end else begin
                        i_reg     <= i_reg + FW'(1);
                        state_reg <= ST_FR_RD;
                    end
                end
                ST_CNT_RD: begin
                    state_reg <= ST_CNT_UPD;
                end
                ST_CNT_UPD: begin
                    rcnt_reg  <= cnt_wdata;
                    rins_reg  <= 1'b0;
                    rdrop_reg <= 1'b0;
                    state_reg <= ST_DONE;
                end
                ST_MISS: begin
                    i_reg <= '0;
                    if (used_reg < EW'(TABLE_ENTRIES)) begin
                        state_reg <= ST_CP_RD;
                    end else begin
                        rcnt_reg  <= '0;
                        rins_reg  <= 1'b0;
                        rdrop_reg <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_CP_RD: begin
                    state_reg <= ST_CP_WR;
                end
                ST_CP_WR: begin
                    if (last_i) begin
                        used_reg  <= used_reg + EW'(1);
                        rcnt_reg  <= COUNT_W'(1);
                        rins_reg  <= 1'b1;
                        rdrop_reg <= 1'b0;
                        state_reg <= ST_DONE;
                    end else begin
                        i_reg     <= i_reg + FW'(1);
                        state_reg <= ST_CP_RD;
                    end
                end
                ST_DONE: begin
                    // hold until the result register is free
                    if (out_free) begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= {5'b0, total_next, used_wide[8:0], rdrop_reg,
                                       rins_reg, rcnt_reg,
                                       rdrop_reg ? 8'd0 : e_wide[7:0]};
                        total_reg  <= total_next;
                        plen_reg   <= '0;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/sstc_checker.sv */
// ----------------------------------------------------------------------------
// sstc_checker - port-level checks for the stack signature count table
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module sstc_checker
    import sstc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic ins;
    logic drop;
    assign ins  = m_tdata[RES_INS_BIT];
    assign drop = m_tdata[RES_DROP_BIT];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ins_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(ins && drop))
        else $error("request both inserted and dropped");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && drop |-> m_tdata[RES_INS_BIT-1:0] == '0)
        else $error("dropped request carries index or count");

    a_ins_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ins |-> m_tdata[RES_INS_BIT-1:RES_CNT_LSB] == 32'd1)
        else $error("new entry count is not one");

endmodule

bind stack_signature_count_table sstc_checker u_sstc_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata)
);
